// ===== rtl/mrtu_pkg.sv =====
`timescale 1ns / 1ps

package mrtu_pkg;

	// receive store
	localparam int FRAME_BYTES     = 32;
	localparam int MAX_WRITE_WORDS = 4;
	localparam int ADDR_W          = $clog2(FRAME_BYTES);
	localparam int LEN_W           = $clog2(FRAME_BYTES + 2);
	localparam int WCNT_W          = 5;

	// crc-16, reflected
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// request operations
	localparam logic [1:0] OP_WRITE_SINGLE = 2'd0;
	localparam logic [1:0] OP_WRITE_MULTI  = 2'd1;
	localparam logic [1:0] OP_READ_HOLD    = 2'd2;
	localparam logic [1:0] OP_BAD          = 2'd3;

	// function codes
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
	localparam logic [7:0] FC_READ_HOLD    = 8'h03;
	localparam logic [7:0] FC_EXC_LO       = 8'h80;
	localparam logic [7:0] FC_EXC_HI       = 8'h90;

	// verdict codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_CRC_FAIL  = 3'd2;
	localparam logic [2:0] ST_BAD_ID_FC = 3'd3;
	localparam logic [2:0] ST_ECHO      = 3'd4;
	localparam logic [2:0] ST_EXCEPTION = 3'd5;
	localparam logic [2:0] ST_NO_REQ    = 3'd6;

	// register map
	localparam logic REG_SLAVE_ADDRESS = 1'b0;

	typedef struct packed {
		logic        start;
		logic [15:0] crc_in;
		logic [7:0]  data;
	} crc_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TX_EMIT,
		S_TX_CRC,
		S_TX_LO,
		S_TX_HI,
		S_RX_CRC,
		S_V_RD,
		S_V_CAP,
		S_V_EVAL,
		S_V_OUT,
		S_W_RD_HI,
		S_W_CAP_HI,
		S_W_RD_LO,
		S_W_CAP_LO,
		S_W_OUT
	} state_t;

endpackage

// ===== rtl/mrtu_ram.sv =====
`timescale 1ns / 1ps

module mrtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/mrtu_crc.sv =====
`timescale 1ns / 1ps

// bit-serial crc-16, busy until all eight bits of a byte are shifted
module mrtu_crc import mrtu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  crc_req_t    req,
	output logic        busy,
	output logic [15:0] crc
);

	logic [3:0]  cnt_q;
	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 4'd8;
		end else if (cnt_q != 4'd0) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			crc_q <= req.crc_in ^ {8'h00, req.data};
		end else if (cnt_q != 4'd0) begin
			crc_q <= crc_q[0] ? ({1'b0, crc_q[15:1]} ^ CRC_POLY) : {1'b0, crc_q[15:1]};
		end
	end

	assign busy = (cnt_q != 4'd0);
	assign crc  = crc_q;

endmodule

// ===== rtl/modbus_rtu_master_frame_engine.sv =====
`timescale 1ns / 1ps

// modbus rtu master framing and response checking
// input stream: tuser 0 carries a request (op, address, value or count, up to four
// words); tuser 1 carries one received response byte, tlast marking the frame end
// output stream: tuser 1 is a request byte to send, tuser 0 a verdict or a read word
// a request gives 8 bytes (write single, read) or 9+2*count bytes (write multiple),
// crc low byte first; each data byte is emitted and then shifted bit by bit through
// the bit-serial crc unit, which signals done before the next byte is emitted; the
// two crc bytes then follow, each as soon as the output register is free
// a response byte is written to the store and run through the crc unit; the last
// byte then runs the verdict: with a request pending, five store reads, each read and
// captured, an evaluation, the verdict, then per word of a good read a high and a low
// byte read and capture and the word out, all through the single registered read port
// the input is not ready while an item is in work; it is ready again as soon as the
// last result sits in the output register, even if the receiver has not taken it
// a stalled receiver holds the output register and the sequencer waits on it
// reset: slave address 1, no pending request, empty receive buffer; the store
// needs no clearing pass, bytes outside the current frame never decide a verdict
// slave_address sits at apb byte address 0
module modbus_rtu_master_frame_engine import mrtu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// apb configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// request_op[1:0], reg_address[17:2], value_or_count[33:18], word_1[49:34],
	// word_2[65:50], word_3[81:66], word_4[97:82], rx_byte[105:98], zero fill
	input  logic [111:0] s_tdata,
	// kind
	input  logic         s_tuser,
	// rx_last
	input  logic         s_tlast,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// tx_byte[7:0], status[10:8], exception_code[18:11], reg_valid[19],
	// reg_index[23:20], reg_value[39:24]
	output logic [39:0]  m_tdata,
	// is_tx
	output logic         m_tuser,
	// last
	output logic         m_tlast
);

	// input fields
	logic        in_kind;
	logic [1:0]  in_op;
	logic [15:0] in_addr;
	logic [15:0] in_voc;
	logic [15:0] in_word [MAX_WRITE_WORDS];
	logic [7:0]  in_rx_byte;
	logic        in_fire;
	logic        req_bad;

	assign in_kind    = s_tuser;
	assign in_op      = s_tdata[1:0];
	assign in_addr    = s_tdata[17:2];
	assign in_voc     = s_tdata[33:18];
	assign in_rx_byte = s_tdata[105:98];

	always_comb begin
		for (int k = 0; k < MAX_WRITE_WORDS; k++) begin
			in_word[k] = s_tdata[34 + 16*k +: 16];
		end
	end

	assign req_bad = (in_op == OP_BAD) ||
		((in_op == OP_WRITE_MULTI) &&
		 ((in_voc == 16'd0) || (in_voc > 16'(MAX_WRITE_WORDS))));

	// configuration
	logic [7:0] slave_address_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SLAVE_ADDRESS);
	assign prdata = (paddr[2] == REG_SLAVE_ADDRESS) ? {24'h0, slave_address_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
		end else if (cfg_wr) begin
			slave_address_q <= pwdata[7:0];
		end
	end

	// sequencer state
	state_t state_q, state_d;

	// request held for framing
	logic [1:0]  op_q;
	logic [15:0] addr_q;
	logic [15:0] voc_q;
	logic [15:0] words_q [MAX_WRITE_WORDS];
	logic [4:0]  tx_idx_q;
	logic [4:0]  tx_n_q;
	logic [15:0] tx_crc_q;

	// pending request
	logic        pending_valid_q;
	logic [1:0]  pending_op_q;
	logic [15:0] request_crc_q;
	logic [7:0]  request_addr_high_q;

	// receive side
	logic [LEN_W-1:0] len_q;
	logic [15:0]      running_crc_q;
	logic [15:0]      hist0_q;
	logic [15:0]      hist1_q;
	logic [15:0]      after_six_q;
	logic             rx_last_q;

	// verdict
	logic [2:0]        step_q;
	logic [7:0]        b0_q, b1_q, b2_q, clo_q, chi_q;
	logic [2:0]        st_q;
	logic [7:0]        exc_q;
	logic [WCNT_W-1:0] wcnt_q;
	logic [3:0]        widx_q;
	logic [7:0]        whi_q, wlo_q;

	// output register
	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic        out_user_q;
	logic        out_last_q;
	logic        slot_free;

	// crc unit and store
	crc_req_t          crc_req;
	logic              crc_busy;
	logic [15:0]       crc_out;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	// combinational control
	logic        out_load;
	logic [39:0] out_data_d;
	logic        out_user_d;
	logic        out_last_d;
	logic        go_verdict;
	logic        end_frame;
	logic [7:0]  tx_byte_sel;
	logic [7:0]  fc_sel;
	logic [ADDR_W-1:0] crc_lo_addr;
	logic [15:0] crc_word;
	logic [2:0]  st_eval;
	logic [WCNT_W-1:0] wcnt_eval;
	logic [7:0]  w_from_count;
	logic [7:0]  w_from_len;
	logic        word_is_last;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign in_fire   = s_tvalid && s_tready;

	mrtu_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crc_req),
		.busy   (crc_busy),
		.crc    (crc_out)
	);

	mrtu_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (len_q[ADDR_W-1:0]),
		.wdata (in_rx_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// function code of the held request
	always_comb begin
		case (op_q)
			OP_WRITE_SINGLE: fc_sel = FC_WRITE_SINGLE;
			OP_WRITE_MULTI:  fc_sel = FC_WRITE_MULTI;
			default:         fc_sel = FC_READ_HOLD;
		endcase
	end

	// request frame byte at the current index
	always_comb begin
		logic [4:0] rel;
		rel = tx_idx_q - 5'd7;
		case (tx_idx_q)
			5'd0:    tx_byte_sel = slave_address_q;
			5'd1:    tx_byte_sel = fc_sel;
			5'd2:    tx_byte_sel = addr_q[15:8];
			5'd3:    tx_byte_sel = addr_q[7:0];
			5'd4:    tx_byte_sel = voc_q[15:8];
			5'd5:    tx_byte_sel = voc_q[7:0];
			5'd6:    tx_byte_sel = {voc_q[6:0], 1'b0};
			default: tx_byte_sel = rel[0] ? words_q[rel[2:1]][7:0] : words_q[rel[2:1]][15:8];
		endcase
	end

	// crc word sits after six bytes for a write single echo (unless the frame has five bytes), else at the frame end
	assign crc_lo_addr = ((pending_op_q == OP_WRITE_SINGLE) && (len_q != LEN_W'(5))) ?
		ADDR_W'(6) : ADDR_W'(len_q - LEN_W'(2));
	assign crc_word = {chi_q, clo_q};

	assign w_from_count = {1'b0, b2_q[7:1]};
	assign w_from_len   = 8'((len_q - LEN_W'(5)) >> 1);

	// verdict evaluation, frame length tested before any stored byte
	always_comb begin
		logic [7:0] w;
		st_eval   = ST_OK;
		wcnt_eval = '0;
		w = (w_from_count < w_from_len) ? w_from_count : w_from_len;
		if (w > 8'd16) begin
			w = 8'd16;
		end
		if (len_q > LEN_W'(FRAME_BYTES)) begin
			st_eval = ST_CRC_FAIL;
		end else if ((len_q == LEN_W'(5)) && (b1_q >= FC_EXC_LO) && (b1_q <= FC_EXC_HI)) begin
			st_eval = (hist1_q == crc_word) ? ST_EXCEPTION : ST_CRC_FAIL;
		end else if (pending_op_q == OP_WRITE_SINGLE) begin
			if (len_q < LEN_W'(8)) begin
				st_eval = ST_SHORT;
			end else if (after_six_q != crc_word) begin
				st_eval = ST_CRC_FAIL;
			end else if (crc_word != request_crc_q) begin
				st_eval = ST_ECHO;
			end
		end else if (pending_op_q == OP_WRITE_MULTI) begin
			if (len_q < LEN_W'(8)) begin
				st_eval = ST_SHORT;
			end else if (hist1_q != crc_word) begin
				st_eval = ST_CRC_FAIL;
			end else if ((b0_q != slave_address_q) || (b1_q != FC_WRITE_MULTI)) begin
				st_eval = ST_BAD_ID_FC;
			end else if (b2_q != request_addr_high_q) begin
				st_eval = ST_ECHO;
			end
		end else begin
			if (len_q < LEN_W'(5)) begin
				st_eval = ST_SHORT;
			end else if (hist1_q != crc_word) begin
				st_eval = ST_CRC_FAIL;
			end else if ((b0_q != slave_address_q) || (b1_q != FC_READ_HOLD)) begin
				st_eval = ST_BAD_ID_FC;
			end else begin
				wcnt_eval = WCNT_W'(w);
			end
		end
	end

	assign word_is_last = ({1'b0, widx_q} == (wcnt_q - WCNT_W'(1)));

	// next state and control
	always_comb begin
		state_d    = state_q;
		crc_req    = '0;
		ram_we     = 1'b0;
		ram_raddr  = '0;
		out_load   = 1'b0;
		out_data_d = '0;
		out_user_d = 1'b0;
		out_last_d = 1'b0;
		go_verdict = 1'b0;
		end_frame  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (!in_kind) begin
						if (!req_bad) begin
							state_d = S_TX_EMIT;
						end
					end else if (len_q < LEN_W'(FRAME_BYTES)) begin
						ram_we         = 1'b1;
						crc_req.start  = 1'b1;
						crc_req.crc_in = running_crc_q;
						crc_req.data   = in_rx_byte;
						state_d        = S_RX_CRC;
					end else if (s_tlast) begin
						go_verdict = 1'b1;
						state_d    = pending_valid_q ? S_V_RD : S_V_OUT;
					end
				end
			end
			S_TX_EMIT: begin
				if (slot_free) begin
					out_load         = 1'b1;
					out_data_d[7:0]  = tx_byte_sel;
					out_user_d       = 1'b1;
					crc_req.start    = 1'b1;
					crc_req.crc_in   = tx_crc_q;
					crc_req.data     = tx_byte_sel;
					state_d          = S_TX_CRC;
				end
			end
			S_TX_CRC: begin
				if (!crc_busy) begin
					state_d = (tx_idx_q == tx_n_q - 5'd1) ? S_TX_LO : S_TX_EMIT;
				end
			end
			S_TX_LO: begin
				if (slot_free) begin
					out_load        = 1'b1;
					out_data_d[7:0] = tx_crc_q[7:0];
					out_user_d      = 1'b1;
					state_d         = S_TX_HI;
				end
			end
			S_TX_HI: begin
				if (slot_free) begin
					out_load        = 1'b1;
					out_data_d[7:0] = tx_crc_q[15:8];
					out_user_d      = 1'b1;
					out_last_d      = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_RX_CRC: begin
				if (!crc_busy) begin
					if (rx_last_q) begin
						go_verdict = 1'b1;
						state_d    = pending_valid_q ? S_V_RD : S_V_OUT;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_V_RD: begin
				case (step_q)
					3'd0:    ram_raddr = ADDR_W'(0);
					3'd1:    ram_raddr = ADDR_W'(1);
					3'd2:    ram_raddr = ADDR_W'(2);
					3'd3:    ram_raddr = crc_lo_addr;
					default: ram_raddr = crc_lo_addr + ADDR_W'(1);
				endcase
				state_d = S_V_CAP;
			end
			S_V_CAP: begin
				state_d = (step_q == 3'd4) ? S_V_EVAL : S_V_RD;
			end
			S_V_EVAL: begin
				state_d = S_V_OUT;
			end
			S_V_OUT: begin
				if (slot_free) begin
					out_load          = 1'b1;
					out_data_d[10:8]  = st_q;
					out_data_d[18:11] = exc_q;
					out_last_d        = (wcnt_q == '0);
					if (wcnt_q == '0) begin
						end_frame = 1'b1;
						state_d   = S_IDLE;
					end else begin
						state_d = S_W_RD_HI;
					end
				end
			end
			S_W_RD_HI: begin
				ram_raddr = ADDR_W'({widx_q, 1'b0}) + ADDR_W'(3);
				state_d   = S_W_CAP_HI;
			end
			S_W_CAP_HI: begin
				state_d = S_W_RD_LO;
			end
			S_W_RD_LO: begin
				ram_raddr = ADDR_W'({widx_q, 1'b0}) + ADDR_W'(4);
				state_d   = S_W_CAP_LO;
			end
			S_W_CAP_LO: begin
				state_d = S_W_OUT;
			end
			S_W_OUT: begin
				if (slot_free) begin
					out_load           = 1'b1;
					out_data_d[19]     = 1'b1;
					out_data_d[23:20]  = widx_q;
					out_data_d[39:24]  = {whi_q, wlo_q};
					out_last_d         = word_is_last;
					if (word_is_last) begin
						end_frame = 1'b1;
						state_d   = S_IDLE;
					end else begin
						state_d = S_W_RD_HI;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_valid_q     <= 1'b0;
			pending_op_q        <= OP_WRITE_SINGLE;
			request_crc_q       <= '0;
			request_addr_high_q <= '0;
			len_q               <= '0;
			running_crc_q       <= CRC_INIT;
			hist0_q             <= CRC_INIT;
			hist1_q             <= CRC_INIT;
			after_six_q         <= CRC_INIT;
			out_valid_q         <= 1'b0;
			tx_idx_q            <= '0;
			step_q              <= '0;
			widx_q              <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (in_fire && !in_kind && !req_bad) begin
				tx_idx_q <= '0;
			end
			if ((state_q == S_TX_CRC) && !crc_busy) begin
				tx_idx_q <= tx_idx_q + 5'd1;
			end

			// request committed once its last byte is out
			if ((state_q == S_TX_HI) && slot_free) begin
				pending_valid_q     <= 1'b1;
				pending_op_q        <= op_q;
				request_crc_q       <= tx_crc_q;
				request_addr_high_q <= addr_q[15:8];
			end

			// receive byte
			if (in_fire && in_kind) begin
				if (len_q < LEN_W'(FRAME_BYTES)) begin
					hist1_q <= hist0_q;
					hist0_q <= running_crc_q;
					len_q   <= len_q + LEN_W'(1);
				end else begin
					len_q <= LEN_W'(FRAME_BYTES + 1);
				end
			end
			if ((state_q == S_RX_CRC) && !crc_busy) begin
				running_crc_q <= crc_out;
				if (len_q == LEN_W'(6)) begin
					after_six_q <= crc_out;
				end
			end

			if (go_verdict) begin
				step_q <= '0;
			end
			if (state_q == S_V_CAP) begin
				step_q <= step_q + 3'd1;
			end
			if (state_q == S_V_OUT) begin
				widx_q <= '0;
			end
			if ((state_q == S_W_OUT) && slot_free) begin
				widx_q <= widx_q + 4'd1;
			end

			// any verdict ends the pending request, a new request drops a partial frame
			if (end_frame || ((state_q == S_TX_HI) && slot_free)) begin
				len_q         <= '0;
				running_crc_q <= CRC_INIT;
				hist0_q       <= CRC_INIT;
				hist1_q       <= CRC_INIT;
				after_six_q   <= CRC_INIT;
			end
			if (end_frame) begin
				pending_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire && !in_kind) begin
			op_q   <= in_op;
			addr_q <= in_addr;
			voc_q  <= in_voc;
			for (int k = 0; k < MAX_WRITE_WORDS; k++) begin
				words_q[k] <= in_word[k];
			end
			tx_n_q   <= (in_op == OP_WRITE_MULTI) ? (5'd7 + {in_voc[3:0], 1'b0}) : 5'd6;
			tx_crc_q <= CRC_INIT;
		end
		if ((state_q == S_TX_CRC) && !crc_busy) begin
			tx_crc_q <= crc_out;
		end
		if (in_fire && in_kind) begin
			rx_last_q <= s_tlast;
		end
		if (go_verdict) begin
			st_q   <= ST_NO_REQ;
			exc_q  <= '0;
			wcnt_q <= '0;
		end
		if (state_q == S_V_CAP) begin
			case (step_q)
				3'd0:    b0_q  <= ram_rdata;
				3'd1:    b1_q  <= ram_rdata;
				3'd2:    b2_q  <= ram_rdata;
				3'd3:    clo_q <= ram_rdata;
				default: chi_q <= ram_rdata;
			endcase
		end
		if (state_q == S_V_EVAL) begin
			st_q   <= st_eval;
			exc_q  <= (st_eval == ST_EXCEPTION) ? b2_q : 8'h00;
			wcnt_q <= wcnt_eval;
		end
		if (state_q == S_W_CAP_HI) begin
			whi_q <= ram_rdata;
		end
		if (state_q == S_W_CAP_LO) begin
			wlo_q <= ram_rdata;
		end
		if (out_load) begin
			out_data_q <= out_data_d;
			out_user_q <= out_user_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule
